// File: src/stl_pkg.sv
// Shared types, token codes, character codes and keyword tables of the script token lexer.
package stl_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_MINUS,
        MODE_BRACE,
        MODE_SEL,
        MODE_SEL_CLOSE
    } scan_mode_t;

    localparam logic [5:0] KIND_EOF      = 6'd0;
    localparam logic [5:0] KIND_IDENT    = 6'd1;
    localparam logic [5:0] KIND_NUMBER   = 6'd2;
    localparam logic [5:0] KIND_STRING   = 6'd3;
    localparam logic [5:0] KIND_SELECTOR = 6'd4;
    localparam logic [5:0] KIND_KEYWORD0 = 6'd5;
    localparam logic [5:0] KIND_EQUALS   = 6'd21;
    localparam logic [5:0] KIND_COLON    = 6'd22;
    localparam logic [5:0] KIND_COMMA    = 6'd23;
    localparam logic [5:0] KIND_SEMI     = 6'd24;
    localparam logic [5:0] KIND_DOT      = 6'd25;
    localparam logic [5:0] KIND_PIPE     = 6'd26;
    localparam logic [5:0] KIND_LPAREN   = 6'd27;
    localparam logic [5:0] KIND_RPAREN   = 6'd28;
    localparam logic [5:0] KIND_LBRACE   = 6'd29;
    localparam logic [5:0] KIND_RBRACE   = 6'd30;
    localparam logic [5:0] KIND_LBRACKET = 6'd31;
    localparam logic [5:0] KIND_RBRACKET = 6'd32;
    localparam logic [5:0] KIND_AMP      = 6'd33;
    localparam logic [5:0] KIND_ARROW    = 6'd34;
    localparam logic [5:0] KIND_ERROR    = 6'd35;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_AMP        = 8'h26;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT0     = 8'h30;
    localparam logic [7:0] CH_DIGIT9     = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_GT         = 8'h3E;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_PIPE       = 8'h7C;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    localparam int KW_TOTAL = 16;

    // Keyword text is right-aligned: the first character sits highest.
    localparam logic [79:0] KW_TEXT [KW_TOTAL] = '{
        80'("fileloader"), 80'("script"), 80'("animate"), 80'("listen"),
        80'("util"), 80'("change"), 80'("then"), 80'("if"),
        80'("else"), 80'("for"), 80'("while"), 80'("function"),
        80'("return"), 80'("var"), 80'("let"), 80'("const")
    };

    localparam logic [3:0] KW_LEN [KW_TOTAL] = '{
        4'd10, 4'd6, 4'd7, 4'd6, 4'd4, 4'd6, 4'd4, 4'd2,
        4'd4, 4'd3, 4'd5, 4'd8, 4'd6, 4'd3, 4'd3, 4'd5
    };

    function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] pos);
        logic [79:0] text;
        logic [3:0]  idx;
        text = KW_TEXT[k];
        idx  = KW_LEN[k] - 4'd1 - pos;
        return text[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [5:0] op_kind(input logic [7:0] c);
        logic [5:0] kind;
        unique case (c)
            CH_EQUALS:   kind = KIND_EQUALS;
            CH_COLON:    kind = KIND_COLON;
            CH_COMMA:    kind = KIND_COMMA;
            CH_SEMI:     kind = KIND_SEMI;
            CH_DOT:      kind = KIND_DOT;
            CH_PIPE:     kind = KIND_PIPE;
            CH_LPAREN:   kind = KIND_LPAREN;
            CH_RPAREN:   kind = KIND_RPAREN;
            CH_LBRACE:   kind = KIND_LBRACE;
            CH_RBRACE:   kind = KIND_RBRACE;
            CH_LBRACKET: kind = KIND_LBRACKET;
            CH_RBRACKET: kind = KIND_RBRACKET;
            CH_AMP:      kind = KIND_AMP;
            default:     kind = KIND_ERROR;
        endcase
        return kind;
    endfunction

endpackage

// File: src/stl_in_if.sv
// Source byte channel of the script token lexer.
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

// File: src/stl_out_if.sv
// Token record channel of the script token lexer.
interface stl_out_if #(
    parameter int LENGTH_WIDTH   = 16,
    parameter int POSITION_WIDTH = 24
);
    logic                      valid;
    logic                      ready;
    logic [5:0]                token_kind;
    logic [LENGTH_WIDTH-1:0]   token_length;
    logic [POSITION_WIDTH-1:0] end_line;
    logic [POSITION_WIDTH-1:0] end_column;
    logic [POSITION_WIDTH-1:0] end_offset;
    logic [7:0]                bad_byte;
    logic                      last_of_run;

    modport source (
        output valid, output token_kind, output token_length, output end_line,
        output end_column, output end_offset, output bad_byte, output last_of_run,
        input ready
    );
    modport sink (
        input valid, input token_kind, input token_length, input end_line,
        input end_column, input end_offset, input bad_byte, input last_of_run,
        output ready
    );
endinterface

// File: src/script_token_lexer_core.sv
// Top level of the script token lexer: byte scanner and token record queue.
//
// Source bytes enter on in_ch, one word per byte, or a word with end_of_input
// set to mark the end of the source. Token records leave on out_ch, one word
// per token, carrying kind, length, end position and the offending byte of an
// error token; last_of_run flags the final record caused by one input word.
// One input word causes no record, one record, or two records (a pending
// token ended by the byte plus the byte's own token, or a pending token plus
// end of file). After the end mark every further word gives one eof record.
// The scanner state updates in the cycle a byte is accepted, so a byte can be
// taken every cycle; records reach out_ch only through the registered queue.
// Records wait in a four-entry queue, and in_ch.ready is high while at least
// two entries are free, so the block keeps one byte per cycle as long as the
// receiver drains one record per cycle. When the receiver stalls, records
// stay queued and in_ch.ready drops once fewer than two entries are free.
// Reset clears the queue and returns to line 1, column 1, offset 0, with no
// token pending and the end mark not yet seen.
module script_token_lexer_core #(
    parameter int LENGTH_WIDTH   = 16,
    parameter int POSITION_WIDTH = 24,
    parameter int KEYWORD_COUNT  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    stl_in_if.sink    in_ch,
    stl_out_if.source out_ch
);
    import stl_pkg::*;

    localparam int KW_USED     = (KEYWORD_COUNT < KW_TOTAL) ? KEYWORD_COUNT : KW_TOTAL;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [5:0]                kind;
        logic [LENGTH_WIDTH-1:0]   len;
        logic [POSITION_WIDTH-1:0] line;
        logic [POSITION_WIDTH-1:0] col;
        logic [POSITION_WIDTH-1:0] off;
        logic [7:0]                bad;
        logic                      last;
    } result_t;

    function automatic result_t mk_res(
        input logic [5:0]                kind,
        input logic [LENGTH_WIDTH-1:0]   len,
        input logic [7:0]                bad,
        input logic [POSITION_WIDTH-1:0] line,
        input logic [POSITION_WIDTH-1:0] col,
        input logic [POSITION_WIDTH-1:0] off
    );
        result_t r;
        r.kind = kind;
        r.len  = len;
        r.bad  = bad;
        r.line = line;
        r.col  = col;
        r.off  = off;
        r.last = 1'b0;
        return r;
    endfunction

    scan_mode_t                mode_reg, mode_next;
    logic                      quote_single_reg, quote_single_next;
    logic [KW_USED-1:0]        cand_reg, cand_next;
    logic [LENGTH_WIDTH-1:0]   vlen_reg, vlen_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [POSITION_WIDTH-1:0] col_reg, col_next;
    logic [POSITION_WIDTH-1:0] off_reg, off_next;
    logic                      ended_reg, ended_next;

    result_t                   queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [PTR_W-1:0]          wr_alt;

    logic                      accept, pop;
    logic [7:0]                c;
    logic [POSITION_WIDTH-1:0] line_adv, col_adv, off_adv;
    logic [LENGTH_WIDTH-1:0]   vlen_grow, vlen_grow2;
    logic                      is_alpha, is_digit, is_space, is_ident_ch;
    logic [KW_USED-1:0]        cand_filt, cand_first;
    logic [5:0]                id_kind;

    logic                      fl_valid;
    logic [5:0]                fl_kind;
    logic [LENGTH_WIDTH-1:0]   fl_len;
    logic [7:0]                fl_bad;

    scan_mode_t                fr_mode;
    logic                      fr_emit;
    logic [5:0]                fr_kind;
    logic [7:0]                fr_bad;

    result_t                   res0, res1, fl_res, fr_res;
    logic [1:0]                n_res;

    assign accept = in_ch.valid && in_ch.ready;
    assign pop    = out_ch.valid && out_ch.ready;
    assign c      = in_ch.char_byte;

    // Character classes and saturating counters.
    always_comb
    begin
        is_alpha    = (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
        is_digit    = (c >= CH_DIGIT0 && c <= CH_DIGIT9);
        is_space    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        is_ident_ch = is_alpha || is_digit || (c == CH_UNDERSCORE);

        off_adv = (off_reg == POS_MAX) ? off_reg : off_reg + 1'b1;
        if (c == CH_NEWLINE)
        begin
            line_adv = (line_reg == POS_MAX) ? line_reg : line_reg + 1'b1;
            col_adv  = POSITION_WIDTH'(1);
        end
        else
        begin
            line_adv = line_reg;
            col_adv  = (col_reg == POS_MAX) ? col_reg : col_reg + 1'b1;
        end

        vlen_grow  = (vlen_reg == LEN_MAX) ? vlen_reg : vlen_reg + 1'b1;
        vlen_grow2 = (vlen_reg >= LEN_MAX - 1'b1) ? LEN_MAX : vlen_reg + 2'd2;
    end

    // Keyword candidates: narrowing by the current byte, and the match at token end.
    always_comb
    begin
        for (int k = 0; k < KW_USED; k++)
        begin
            cand_filt[k]  = cand_reg[k]
                && (vlen_reg < LENGTH_WIDTH'(KW_LEN[4'(k)]))
                && (kw_char(4'(k), vlen_reg[3:0]) == c);
            cand_first[k] = (kw_char(4'(k), 4'd0) == c);
        end
        id_kind = KIND_IDENT;
        for (int k = KW_USED - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (LENGTH_WIDTH'(KW_LEN[4'(k)]) == vlen_reg))
            begin
                id_kind = KIND_KEYWORD0 + 6'(k);
            end
        end
    end

    // Token left pending by the current mode, as reported when it is cut short.
    always_comb
    begin
        fl_valid = 1'b1;
        fl_len   = vlen_reg;
        fl_bad   = 8'd0;
        fl_kind  = KIND_EOF;
        unique case (mode_reg)
            MODE_IDENT:     fl_kind = id_kind;
            MODE_NUMBER:    fl_kind = KIND_NUMBER;
            MODE_STRING:    fl_kind = KIND_STRING;
            MODE_SLASH:
            begin
                fl_kind = KIND_ERROR;
                fl_len  = LENGTH_WIDTH'(1);
                fl_bad  = CH_SLASH;
            end
            MODE_MINUS:
            begin
                fl_kind = KIND_ERROR;
                fl_len  = LENGTH_WIDTH'(1);
                fl_bad  = CH_MINUS;
            end
            MODE_BRACE:
            begin
                fl_kind = KIND_LBRACE;
                fl_len  = LENGTH_WIDTH'(1);
            end
            MODE_SEL:       fl_kind = KIND_SELECTOR;
            MODE_SEL_CLOSE:
            begin
                fl_kind = KIND_SELECTOR;
                fl_len  = vlen_grow;
            end
            default:        fl_valid = 1'b0;
        endcase
        fl_res = mk_res(fl_kind, fl_len, fl_bad, line_reg, col_reg, off_reg);
    end

    // A byte scanned with no token pending.
    always_comb
    begin
        fr_emit = 1'b0;
        fr_kind = op_kind(c);
        fr_bad  = 8'd0;
        priority if (is_space)
            fr_mode = MODE_IDLE;
        else if (c == CH_SLASH)
            fr_mode = MODE_SLASH;
        else if (is_alpha || c == CH_UNDERSCORE)
            fr_mode = MODE_IDENT;
        else if (is_digit)
            fr_mode = MODE_NUMBER;
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
            fr_mode = MODE_STRING;
        else if (c == CH_LBRACE)
            fr_mode = MODE_BRACE;
        else if (c == CH_MINUS)
            fr_mode = MODE_MINUS;
        else
        begin
            fr_mode = MODE_IDLE;
            fr_emit = 1'b1;
            if (fr_kind == KIND_ERROR)
                fr_bad = c;
        end
        fr_res = mk_res(fr_kind, LENGTH_WIDTH'(1), fr_bad, line_adv, col_adv, off_adv);
    end

    // Scanner next state and the records caused by the accepted word.
    always_comb
    begin
        logic restart;
        restart           = 1'b0;
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        cand_next         = cand_reg;
        vlen_next         = vlen_reg;
        line_next         = line_reg;
        col_next          = col_reg;
        off_next          = off_reg;
        ended_next        = ended_reg;
        res0              = '0;
        res1              = '0;
        n_res             = 2'd0;

        if (accept)
        begin
            if (ended_reg)
            begin
                res0  = mk_res(KIND_EOF, '0, 8'd0, line_reg, col_reg, off_reg);
                n_res = 2'd1;
            end
            else if (in_ch.end_of_input)
            begin
                if (fl_valid)
                begin
                    res0  = fl_res;
                    res1  = mk_res(KIND_EOF, '0, 8'd0, line_reg, col_reg, off_reg);
                    n_res = 2'd2;
                end
                else
                begin
                    res0  = mk_res(KIND_EOF, '0, 8'd0, line_reg, col_reg, off_reg);
                    n_res = 2'd1;
                end
                if (mode_reg == MODE_SEL_CLOSE)
                    vlen_next = vlen_grow;
                mode_next  = MODE_IDLE;
                ended_next = 1'b1;
            end
            else
            begin
                line_next = line_adv;
                col_next  = col_adv;
                off_next  = off_adv;
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        if (is_ident_ch)
                        begin
                            cand_next = cand_filt;
                            vlen_next = vlen_grow;
                        end
                        else
                            restart = 1'b1;
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit || c == CH_DOT)
                            vlen_next = vlen_grow;
                        else
                            restart = 1'b1;
                    end
                    MODE_STRING:
                    begin
                        if (c == (quote_single_reg ? CH_SQUOTE : CH_DQUOTE))
                        begin
                            res0 = mk_res(KIND_STRING, vlen_reg, 8'd0,
                                          line_adv, col_adv, off_adv);
                            n_res     = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                            vlen_next = vlen_grow;
                    end
                    MODE_SLASH:
                    begin
                        if (c == CH_SLASH)
                            mode_next = MODE_COMMENT;
                        else
                            restart = 1'b1;
                    end
                    MODE_COMMENT:
                    begin
                        if (c == CH_NEWLINE)
                            mode_next = MODE_IDLE;
                    end
                    MODE_MINUS:
                    begin
                        if (c == CH_GT)
                        begin
                            res0 = mk_res(KIND_ARROW, LENGTH_WIDTH'(1), 8'd0,
                                          line_adv, col_adv, off_adv);
                            n_res     = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                            restart = 1'b1;
                    end
                    MODE_BRACE:
                    begin
                        if (c == CH_LBRACE)
                        begin
                            mode_next = MODE_SEL;
                            vlen_next = '0;
                        end
                        else
                            restart = 1'b1;
                    end
                    MODE_SEL:
                    begin
                        if (c == CH_RBRACE)
                            mode_next = MODE_SEL_CLOSE;
                        else
                            vlen_next = vlen_grow;
                    end
                    MODE_SEL_CLOSE:
                    begin
                        if (c == CH_RBRACE)
                        begin
                            res0 = mk_res(KIND_SELECTOR, vlen_reg, 8'd0,
                                          line_adv, col_adv, off_adv);
                            n_res     = 2'd1;
                            mode_next = MODE_IDLE;
                        end
                        else
                        begin
                            vlen_next = vlen_grow2;
                            mode_next = MODE_SEL;
                        end
                    end
                    default: restart = 1'b1;
                endcase

                if (restart)
                begin
                    mode_next = fr_mode;
                    if (fr_mode == MODE_IDENT)
                    begin
                        cand_next = cand_first;
                        vlen_next = LENGTH_WIDTH'(1);
                    end
                    else if (fr_mode == MODE_NUMBER)
                        vlen_next = LENGTH_WIDTH'(1);
                    else if (fr_mode == MODE_STRING)
                    begin
                        quote_single_next = (c == CH_SQUOTE);
                        vlen_next         = '0;
                    end
                    if (fl_valid)
                    begin
                        res0 = fl_res;
                        if (fr_emit)
                        begin
                            res1  = fr_res;
                            n_res = 2'd2;
                        end
                        else
                            n_res = 2'd1;
                    end
                    else if (fr_emit)
                    begin
                        res0  = fr_res;
                        n_res = 2'd1;
                    end
                end
            end
        end

        res0.last = (n_res == 2'd1);
        res1.last = 1'b1;
    end

    always_comb
    begin
        wr_alt      = wr_ptr_reg + 1'b1;
        wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(n_res) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            quote_single_reg <= 1'b0;
            cand_reg         <= '1;
            vlen_reg         <= '0;
            line_reg         <= POSITION_WIDTH'(1);
            col_reg          <= POSITION_WIDTH'(1);
            off_reg          <= '0;
            ended_reg        <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            cand_reg         <= cand_next;
            vlen_reg         <= vlen_next;
            line_reg         <= line_next;
            col_reg          <= col_next;
            off_reg          <= off_next;
            ended_reg        <= ended_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (n_res == 2'd2)
            queue_reg[wr_alt] <= res1;
    end

    assign in_ch.ready         = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign out_ch.valid        = (count_reg != '0);
    assign out_ch.token_kind   = queue_reg[rd_ptr_reg].kind;
    assign out_ch.token_length = queue_reg[rd_ptr_reg].len;
    assign out_ch.end_line     = queue_reg[rd_ptr_reg].line;
    assign out_ch.end_column   = queue_reg[rd_ptr_reg].col;
    assign out_ch.end_offset   = queue_reg[rd_ptr_reg].off;
    assign out_ch.bad_byte     = queue_reg[rd_ptr_reg].bad;
    assign out_ch.last_of_run  = queue_reg[rd_ptr_reg].last;

endmodule

// File: verif/stl_token_checker.sv
// Token checker: predicts the records of the script token lexer and compares them with the block.
`timescale 1ns / 1ps

module stl_token_checker #(
    parameter int LENGTH_WIDTH   = 16,
    parameter int POSITION_WIDTH = 24,
    parameter int KEYWORD_COUNT  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [7:0]                in_char_byte,
    input  logic                      in_end_of_input,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [5:0]                out_token_kind,
    input  logic [LENGTH_WIDTH-1:0]   out_token_length,
    input  logic [POSITION_WIDTH-1:0] out_end_line,
    input  logic [POSITION_WIDTH-1:0] out_end_column,
    input  logic [POSITION_WIDTH-1:0] out_end_offset,
    input  logic [7:0]                out_bad_byte,
    input  logic                      out_last_of_run,
    output int                        failures,
    output int                        pending_tokens
);
    import stl_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0]   LEN_FULL = '1;
    localparam logic [POSITION_WIDTH-1:0] POS_FULL = '1;
    localparam logic [31:0] KW_VALID =
        (KEYWORD_COUNT >= 32) ? 32'hFFFF_FFFF : ((32'd1 << KEYWORD_COUNT) - 32'd1);

    typedef struct {
        logic [5:0]                kind;
        logic [LENGTH_WIDTH-1:0]   length;
        logic [POSITION_WIDTH-1:0] line;
        logic [POSITION_WIDTH-1:0] column;
        logic [POSITION_WIDTH-1:0] offset;
        logic [7:0]                bad;
        logic                      last;
    } token_rec_t;

    string kw_names [16] = '{
        "fileloader", "script", "animate", "listen", "util", "change", "then", "if",
        "else", "for", "while", "function", "return", "var", "let", "const"
    };

    scan_mode_t                lex_mode;
    bit                        in_single_quote;
    logic [31:0]               kw_mask;
    logic [LENGTH_WIDTH-1:0]   text_len;
    logic [POSITION_WIDTH-1:0] cur_line;
    logic [POSITION_WIDTH-1:0] cur_col;
    logic [POSITION_WIDTH-1:0] cur_offset;
    bit                        source_done;
    int                        mismatches;

    token_rec_t word_tokens [$];
    token_rec_t expected_tokens [$];

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    function automatic bit is_digit_char(input logic [7:0] c);
        return c >= CH_DIGIT0 && c <= CH_DIGIT9;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [5:0] operator_code(input logic [7:0] c);
        case (c)
            CH_EQUALS:   return KIND_EQUALS;
            CH_COLON:    return KIND_COLON;
            CH_COMMA:    return KIND_COMMA;
            CH_SEMI:     return KIND_SEMI;
            CH_DOT:      return KIND_DOT;
            CH_PIPE:     return KIND_PIPE;
            CH_LPAREN:   return KIND_LPAREN;
            CH_RPAREN:   return KIND_RPAREN;
            CH_LBRACE:   return KIND_LBRACE;
            CH_RBRACE:   return KIND_RBRACE;
            CH_LBRACKET: return KIND_LBRACKET;
            CH_RBRACKET: return KIND_RBRACKET;
            CH_AMP:      return KIND_AMP;
            default:     return KIND_ERROR;
        endcase
    endfunction

    function automatic logic [5:0] keyword_or_ident();
        for (int k = 0; k < 16; k++)
        begin
            if (k < KEYWORD_COUNT && kw_mask[k] && kw_names[k].len() == text_len)
            begin
                return KIND_KEYWORD0 + 6'(k);
            end
        end
        return KIND_IDENT;
    endfunction

    task automatic reset_lexer();
        lex_mode        = MODE_IDLE;
        in_single_quote = 1'b0;
        kw_mask         = KW_VALID;
        text_len        = '0;
        cur_line        = POSITION_WIDTH'(1);
        cur_col         = POSITION_WIDTH'(1);
        cur_offset      = '0;
        source_done     = 1'b0;
    endtask

    task automatic push_token(input logic [5:0] kind, input logic [LENGTH_WIDTH-1:0] len,
                              input logic [7:0] bad);
        token_rec_t t;
        t.kind   = kind;
        t.length = len;
        t.line   = cur_line;
        t.column = cur_col;
        t.offset = cur_offset;
        t.bad    = bad;
        t.last   = 1'b0;
        word_tokens.push_back(t);
    endtask

    task automatic step_position(input logic [7:0] c);
        if (cur_offset != POS_FULL)
        begin
            cur_offset++;
        end
        if (c == CH_NEWLINE)
        begin
            if (cur_line != POS_FULL)
            begin
                cur_line++;
            end
            cur_col = POSITION_WIDTH'(1);
        end
        else if (cur_col != POS_FULL)
        begin
            cur_col++;
        end
    endtask

    task automatic lengthen();
        if (text_len != LEN_FULL)
        begin
            text_len++;
        end
    endtask

    task automatic narrow_keywords(input logic [LENGTH_WIDTH-1:0] pos, input logic [7:0] c);
        for (int k = 0; k < 16; k++)
        begin
            if (!(pos < kw_names[k].len() && kw_names[k][pos] == c))
            begin
                kw_mask[k] = 1'b0;
            end
        end
        kw_mask &= KW_VALID;
    endtask

    task automatic start_token(input logic [7:0] c);
        logic [5:0] kind;
        lex_mode = MODE_IDLE;
        step_position(c);
        if (is_blank(c))
        begin
            lex_mode = MODE_IDLE;
        end
        else if (c == CH_SLASH)
        begin
            lex_mode = MODE_SLASH;
        end
        else if (is_letter(c) || c == CH_UNDERSCORE)
        begin
            lex_mode = MODE_IDENT;
            kw_mask  = KW_VALID;
            narrow_keywords('0, c);
            text_len = LENGTH_WIDTH'(1);
        end
        else if (is_digit_char(c))
        begin
            lex_mode = MODE_NUMBER;
            text_len = LENGTH_WIDTH'(1);
        end
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            lex_mode        = MODE_STRING;
            in_single_quote = (c == CH_SQUOTE);
            text_len        = '0;
        end
        else if (c == CH_LBRACE)
        begin
            lex_mode = MODE_BRACE;
        end
        else if (c == CH_MINUS)
        begin
            lex_mode = MODE_MINUS;
        end
        else
        begin
            kind = operator_code(c);
            push_token(kind, LENGTH_WIDTH'(1), (kind == KIND_ERROR) ? c : 8'h00);
        end
    endtask

    task automatic close_pending();
        case (lex_mode)
            MODE_IDENT:  push_token(keyword_or_ident(), text_len, 8'h00);
            MODE_NUMBER: push_token(KIND_NUMBER, text_len, 8'h00);
            MODE_STRING: push_token(KIND_STRING, text_len, 8'h00);
            MODE_SLASH:  push_token(KIND_ERROR, LENGTH_WIDTH'(1), CH_SLASH);
            MODE_MINUS:  push_token(KIND_ERROR, LENGTH_WIDTH'(1), CH_MINUS);
            MODE_BRACE:  push_token(KIND_LBRACE, LENGTH_WIDTH'(1), 8'h00);
            MODE_SEL:    push_token(KIND_SELECTOR, text_len, 8'h00);
            MODE_SEL_CLOSE:
            begin
                lengthen();
                push_token(KIND_SELECTOR, text_len, 8'h00);
            end
            default: ;
        endcase
        lex_mode = MODE_IDLE;
    endtask

    task automatic lex_byte(input logic [7:0] c);
        case (lex_mode)
            MODE_IDENT:
                if (is_letter(c) || is_digit_char(c) || c == CH_UNDERSCORE)
                begin
                    step_position(c);
                    narrow_keywords(text_len, c);
                    lengthen();
                end
                else
                begin
                    close_pending();
                    start_token(c);
                end
            MODE_NUMBER:
                if (is_digit_char(c) || c == CH_DOT)
                begin
                    step_position(c);
                    lengthen();
                end
                else
                begin
                    close_pending();
                    start_token(c);
                end
            MODE_STRING:
            begin
                step_position(c);
                if (c == (in_single_quote ? CH_SQUOTE : CH_DQUOTE))
                begin
                    push_token(KIND_STRING, text_len, 8'h00);
                    lex_mode = MODE_IDLE;
                end
                else
                begin
                    lengthen();
                end
            end
            MODE_SLASH:
                if (c == CH_SLASH)
                begin
                    step_position(c);
                    lex_mode = MODE_COMMENT;
                end
                else
                begin
                    close_pending();
                    start_token(c);
                end
            MODE_COMMENT:
            begin
                step_position(c);
                if (c == CH_NEWLINE)
                begin
                    lex_mode = MODE_IDLE;
                end
            end
            MODE_MINUS:
                if (c == CH_GT)
                begin
                    step_position(c);
                    push_token(KIND_ARROW, LENGTH_WIDTH'(1), 8'h00);
                    lex_mode = MODE_IDLE;
                end
                else
                begin
                    close_pending();
                    start_token(c);
                end
            MODE_BRACE:
                if (c == CH_LBRACE)
                begin
                    step_position(c);
                    lex_mode = MODE_SEL;
                    text_len = '0;
                end
                else
                begin
                    close_pending();
                    start_token(c);
                end
            MODE_SEL:
            begin
                step_position(c);
                if (c == CH_RBRACE)
                begin
                    lex_mode = MODE_SEL_CLOSE;
                end
                else
                begin
                    lengthen();
                end
            end
            MODE_SEL_CLOSE:
            begin
                step_position(c);
                if (c == CH_RBRACE)
                begin
                    push_token(KIND_SELECTOR, text_len, 8'h00);
                    lex_mode = MODE_IDLE;
                end
                else
                begin
                    lengthen();
                    lengthen();
                    lex_mode = MODE_SEL;
                end
            end
            default: start_token(c);
        endcase
    endtask

    task automatic lex_word(input logic [7:0] c, input logic at_end);
        token_rec_t t;
        word_tokens.delete();
        if (source_done)
        begin
            push_token(KIND_EOF, '0, 8'h00);
        end
        else if (at_end)
        begin
            close_pending();
            push_token(KIND_EOF, '0, 8'h00);
            source_done = 1'b1;
        end
        else
        begin
            lex_byte(c);
        end
        if (word_tokens.size() > 0)
        begin
            t = word_tokens.pop_back();
            t.last = 1'b1;
            word_tokens.push_back(t);
        end
        foreach (word_tokens[i])
        begin
            expected_tokens.push_back(word_tokens[i]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_token();
        token_rec_t want;
        if (expected_tokens.size() == 0)
        begin
            $error("token_kind: expected no token, got %0d", out_token_kind);
            mismatches++;
        end
        else
        begin
            want = expected_tokens.pop_front();
            check_field("token_kind", 32'(want.kind), 32'(out_token_kind));
            check_field("token_length", 32'(want.length), 32'(out_token_length));
            check_field("end_line", 32'(want.line), 32'(out_end_line));
            check_field("end_column", 32'(want.column), 32'(out_end_column));
            check_field("end_offset", 32'(want.offset), 32'(out_end_offset));
            check_field("bad_byte", 32'(want.bad), 32'(out_bad_byte));
            check_field("last_of_run", 32'(want.last), 32'(out_last_of_run));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_lexer();
            expected_tokens.delete();
            mismatches = 0;
            failures       <= 0;
            pending_tokens <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                lex_word(in_char_byte, in_end_of_input);
            end
            if (out_valid && out_ready)
            begin
                compare_token();
            end
            failures       <= mismatches;
            pending_tokens <= expected_tokens.size();
        end
    end

endmodule

// File: verif/tb_script_token_lexer_core.sv
// Testbench top of the script token lexer: clock, reset, source byte stimulus and verdict.
`timescale 1ns / 1ps

module tb_script_token_lexer_core;
    import stl_pkg::*;

    localparam int LENGTH_WIDTH   = 16;
    localparam int POSITION_WIDTH = 24;
    localparam int KEYWORD_COUNT  = 16;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_BYTES   = 1500;
    localparam int LONG_TEXT      = 60;

    logic clk;
    logic rst_n;
    bit   send_steady;
    bit   take_steady;
    int   bytes_sent;
    int   quiet_cycles;
    int   failures;
    int   pending_tokens;

    string kw_list [16] = '{
        "fileloader", "script", "animate", "listen", "util", "change", "then", "if",
        "else", "for", "while", "function", "return", "var", "let", "const"
    };
    string ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string op_chars    = "=:,;.|(){}[]&";
    string num_chars   = "0123456789.";
    string sep_chars   = " \n;(.";
    string lone_chars  = "-/{";

    stl_in_if in_ch ();
    stl_out_if #(.LENGTH_WIDTH(LENGTH_WIDTH), .POSITION_WIDTH(POSITION_WIDTH)) out_ch ();

    script_token_lexer_core #(
        .LENGTH_WIDTH  (LENGTH_WIDTH),
        .POSITION_WIDTH(POSITION_WIDTH),
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    stl_token_checker #(
        .LENGTH_WIDTH  (LENGTH_WIDTH),
        .POSITION_WIDTH(POSITION_WIDTH),
        .KEYWORD_COUNT (KEYWORD_COUNT)
    ) token_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .in_char_byte    (in_ch.char_byte),
        .in_end_of_input (in_ch.end_of_input),
        .out_valid       (out_ch.valid),
        .out_ready       (out_ch.ready),
        .out_token_kind  (out_ch.token_kind),
        .out_token_length(out_ch.token_length),
        .out_end_line    (out_ch.end_line),
        .out_end_column  (out_ch.end_column),
        .out_end_offset  (out_ch.end_offset),
        .out_bad_byte    (out_ch.bad_byte),
        .out_last_of_run (out_ch.last_of_run),
        .failures        (failures),
        .pending_tokens  (pending_tokens)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ch.ready <= take_steady || ($urandom_range(0, 99) >= 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] byte_excluding(input logic [7:0] avoid);
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (c == avoid);
        return c;
    endfunction

    function automatic logic [7:0] ident_char(input bit first);
        return ident_chars[$urandom_range(0, first ? 52 : 62)];
    endfunction

    task automatic send_word(input logic [7:0] c, input logic at_end);
        while (!send_steady && $urandom_range(0, 99) < 31)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.char_byte    <= c;
        in_ch.end_of_input <= at_end;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], 1'b0);
        end
    endtask

    task automatic send_keyword_like();
        string w;
        int    i;
        w = kw_list[$urandom_range(0, 15)];
        case ($urandom_range(0, 3))
            0: send_text(w);
            1: send_text(w.substr(0, w.len() - 2));
            2:
            begin
                send_text(w);
                send_word(ident_char(1'b0), 1'b0);
            end
            default:
            begin
                i = $urandom_range(0, w.len() - 1);
                w[i] = w[i] - 8'h20;
                send_text(w);
            end
        endcase
        if ($urandom_range(0, 9) < 7)
        begin
            send_word(sep_chars[$urandom_range(0, 4)], 1'b0);
        end
    endtask

    task automatic send_quoted(input int count);
        logic [7:0] q;
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        send_word(q, 1'b0);
        repeat (count)
        begin
            send_word(byte_excluding(q), 1'b0);
        end
        send_word(q, 1'b0);
    endtask

    task automatic send_selector();
        send_text("{{");
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send_word(CH_RBRACE, 1'b0);
            end
            send_word(byte_excluding(CH_RBRACE), 1'b0);
        end
        send_text("}}");
    endtask

    task automatic send_fragment();
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1: send_keyword_like();
            2:
            begin
                send_word(ident_char(1'b1), 1'b0);
                repeat ($urandom_range(0, 11))
                begin
                    send_word(ident_char(1'b0), 1'b0);
                end
            end
            3:
                repeat ($urandom_range(1, 8))
                begin
                    send_word(num_chars[$urandom_range(0, 10)], 1'b0);
                end
            4: send_quoted($urandom_range(0, 10));
            5: send_selector();
            6:
            begin
                send_text("//");
                repeat ($urandom_range(0, 10))
                begin
                    send_word(byte_excluding(CH_NEWLINE), 1'b0);
                end
                send_word(CH_NEWLINE, 1'b0);
            end
            7: send_word(op_chars[$urandom_range(0, 12)], 1'b0);
            8: send_text("->");
            9:
            begin
                c = lone_chars[$urandom_range(0, 2)];
                send_word(c, 1'b0);
                send_word(byte_excluding(c == CH_MINUS ? CH_GT : c), 1'b0);
            end
            10:
            begin
                c = 8'($urandom_range(8, 13));
                send_word((c == 8'd8) ? CH_SPACE : c, 1'b0);
            end
            default: send_word(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endtask

    initial
    begin
        rst_n              = 1'b0;
        send_steady        = 1'b0;
        take_steady        = 1'b0;
        bytes_sent         = 0;
        quiet_cycles       = 0;
        in_ch.valid        = 1'b0;
        in_ch.char_byte    = 8'h00;
        in_ch.end_of_input = 1'b0;
        out_ch.ready       = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_text("{{a}b}}->-x/y'\"'\"\"//\n=:,;.|()}[]&{ \t");

        while (bytes_sent < RANDOM_BYTES)
        begin
            send_steady <= (bytes_sent >= 600 && bytes_sent < 850);
            take_steady <= (bytes_sent >= 900 && bytes_sent < 1100);
            send_fragment();
        end

        send_steady <= 1'b1;
        take_steady <= 1'b1;
        send_quoted(LONG_TEXT);
        send_steady <= 1'b0;
        take_steady <= 1'b0;

        case ($urandom_range(0, 7))
            0: send_text("{{ab}");
            1: send_text("'xy");
            2: send_text(" name");
            3: send_text(" 12");
            4: send_text("/");
            5: send_text("-");
            6: send_text("{");
            default: send_text(" ");
        endcase
        send_word(8'($urandom_range(0, 255)), 1'b1);
        repeat (3)
        begin
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending_tokens != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (failures == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
